[hw/rtl/lepi_pkg.sv]
package lepi_pkg;

  localparam int unsigned CoefWidth  = 24;
  localparam int unsigned CrossWidth = 49;
  localparam int unsigned ProdWidth  = 2 * CoefWidth + 1;
  localparam int unsigned DivSteps   = ProdWidth;
  localparam int unsigned DivCntW    = $clog2(DivSteps + 1);

  typedef logic signed [CoefWidth-1:0]  coef_t;
  typedef logic signed [CrossWidth-1:0] cross_t;

  localparam logic [2:0] StStart  = 3'd0;
  localparam logic [2:0] StSign   = 3'd1;
  localparam logic [2:0] StDigit  = 3'd2;
  localparam logic [2:0] StX      = 3'd3;
  localparam logic [2:0] StY      = 3'd4;
  localparam logic [2:0] StEq     = 3'd5;
  localparam logic [2:0] StAccept = 3'd6;
  localparam logic [2:0] StErr    = 3'd7;

  localparam logic [2:0] ColSign  = 3'd0;
  localparam logic [2:0] ColNz    = 3'd1;
  localparam logic [2:0] ColX     = 3'd2;
  localparam logic [2:0] ColY     = 3'd3;
  localparam logic [2:0] ColEq    = 3'd4;
  localparam logic [2:0] ColZero  = 3'd5;
  localparam logic [2:0] ColBad   = 3'd6;

  // controller to datapath commands
  typedef struct packed {
    logic char_step;
    logic line_end;
    logic calc_start;
    logic div_step;
    logic div_load;
    logic clear_all;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic cur_line;
  } sts_t;

  function automatic logic [2:0] classify(input logic [7:0] c);
    logic [2:0] r;
    r = ColBad;
    if (c == 8'h2b || c == 8'h2d) r = ColSign;
    else if (c == 8'h30) r = ColZero;
    else if (c >= 8'h31 && c <= 8'h39) r = ColNz;
    else if (c == 8'h78) r = ColX;
    else if (c == 8'h79) r = ColY;
    else if (c == 8'h3d) r = ColEq;
    return r;
  endfunction

  function automatic logic [2:0] next_state(input logic [2:0] s, input logic [2:0] col);
    logic [2:0] r;
    r = StErr;
    if (col != ColBad) begin
      unique case (s)
        StStart: begin
          unique case (col)
            ColSign: r = StSign;
            ColX:    r = StX;
            ColY:    r = StY;
            ColEq:   r = StErr;
            default: r = StDigit;
          endcase
        end
        StSign: begin
          unique case (col)
            ColSign, ColEq: r = StErr;
            ColX:    r = StX;
            ColY:    r = StY;
            default: r = StDigit;
          endcase
        end
        StDigit: begin
          unique case (col)
            ColSign: r = StSign;
            ColX:    r = StX;
            ColY:    r = StY;
            ColEq:   r = StEq;
            default: r = StDigit;
          endcase
        end
        StX, StY: begin
          unique case (col)
            ColSign: r = StSign;
            ColEq:   r = StEq;
            default: r = StErr;
          endcase
        end
        StEq:    r = (col == ColZero) ? StAccept : StErr;
        default: r = StErr;
      endcase
    end
    return r;
  endfunction

endpackage

[hw/rtl/lepi_ctrl.sv]
module lepi_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [7:0]     ch_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  lepi_pkg::sts_t sts_i,
  output lepi_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_RUN, S_MUL, S_DLOAD, S_DIV, S_FIN, S_OUT
  } state_e;

  state_e state_q;
  logic [lepi_pkg::DivCntW-1:0] cnt_q;
  logic out_valid_q, out_valid_d;
  logic acc;

  assign in_stall_o  = (state_q != S_RUN) || (out_valid_q && out_stall_i);
  assign acc         = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  // command decode
  always_comb begin
    cmd_o = '0;
    cmd_o.char_step  = acc && (ch_i != 8'd0);
    cmd_o.line_end   = acc && (ch_i == 8'd0);
    cmd_o.calc_start = (state_q == S_MUL);
    cmd_o.div_load   = (state_q == S_DLOAD);
    cmd_o.div_step   = (state_q == S_DIV);
    cmd_o.clear_all  = (state_q == S_FIN);
  end

  // result valid: held while stalled, set by a first line end or a finished pair
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (acc && (ch_i == 8'd0) && !sts_i.cur_line) out_valid_d = 1'b1;
    if (state_q == S_FIN) out_valid_d = 1'b1;
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        S_RUN: begin
          if (acc && ch_i == 8'd0 && sts_i.cur_line) state_q <= S_MUL;
        end
        S_MUL:   state_q <= S_DLOAD;
        S_DLOAD: begin
          state_q <= S_DIV;
          cnt_q   <= '0;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == lepi_pkg::DivCntW'(lepi_pkg::DivSteps - 1)) state_q <= S_FIN;
        end
        S_FIN:   state_q <= S_OUT;
        S_OUT: if (!out_valid_q || !out_stall_i) state_q <= S_RUN;
        default: state_q <= S_RUN;
      endcase
    end
  end

endmodule

[hw/rtl/lepi_dp.sv]
module lepi_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [7:0]             ch_i,
  input  lepi_pkg::cmd_t         cmd_i,
  input  logic                   out_stall_i,
  input  logic                   out_valid_i,
  output lepi_pkg::sts_t         sts_o,
  output logic                   line_index_o,
  output logic                   line_valid_o,
  output lepi_pkg::coef_t        coef_x_o,
  output lepi_pkg::coef_t        coef_y_o,
  output lepi_pkg::coef_t        coef_const_o,
  output logic                   pair_done_o,
  output logic                   pair_valid_o,
  output logic                   parallel_o,
  output lepi_pkg::cross_t       cross_x_o,
  output lepi_pkg::cross_t       cross_y_o
);

  localparam int unsigned W = lepi_pkg::CoefWidth;
  localparam int unsigned P = lepi_pkg::ProdWidth;
  localparam int unsigned C = lepi_pkg::CrossWidth;
  localparam logic [W:0] MagCap = (W+1)'(1) << (W-1);

  logic [2:0] pst_q, pst_d;
  logic       sign_q;
  logic [W:0] mag_q;
  logic       line_q;
  logic       pok_q;
  lepi_pkg::coef_t store_q [6];

  logic [2:0] col;
  logic [W:0] mag_new;
  logic [W+4:0] mag_mul;
  logic [1:0] slot;
  logic       commit;
  logic [2:0] idx;
  logic signed [W+1:0] sum;
  lepi_pkg::coef_t sat;
  logic [W:0] tmag;

  // character parse
  always_comb begin
    col    = lepi_pkg::classify(ch_i);
    pst_d  = (pst_q == lepi_pkg::StErr) ? lepi_pkg::StErr : lepi_pkg::next_state(pst_q, col);
    mag_mul = (W+5)'(mag_q) * (W+5)'(10) + (W+5)'((col == lepi_pkg::ColZero) ? 4'd0 :
              4'(ch_i - 8'h30));
    mag_new = mag_q;
    commit  = 1'b0;
    slot    = 2'd2;
    if (pst_d == lepi_pkg::StDigit) begin
      if (pst_q != lepi_pkg::StDigit)
        mag_new = (W+1)'((col == lepi_pkg::ColZero) ? 4'd0 : 4'(ch_i - 8'h30));
      else
        mag_new = (mag_mul > (W+5)'(MagCap)) ? MagCap : mag_mul[W:0];
    end
    tmag = mag_q;
    if (pst_d == lepi_pkg::StX || pst_d == lepi_pkg::StY) begin
      commit = 1'b1;
      slot   = (pst_d == lepi_pkg::StX) ? 2'd0 : 2'd1;
      if (pst_q != lepi_pkg::StDigit) tmag = (W+1)'(1);
    end
    if (pst_q == lepi_pkg::StDigit && (pst_d == lepi_pkg::StSign || pst_d == lepi_pkg::StEq))
      commit = 1'b1;
    idx = line_q ? 3'(slot) + 3'd3 : 3'(slot);
    sum = (W+2)'(store_q[idx]) + (sign_q ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag}));
    if (sum > (W+2)'($signed({2'b0, {(W-1){1'b1}}}))) sat = {1'b0, {(W-1){1'b1}}};
    else if (sum < -(W+2)'($signed({2'b0, 1'b1, {(W-1){1'b0}}}))) sat = {1'b1, {(W-1){1'b0}}};
    else sat = sum[W-1:0];
  end

  // multiply stage and divider
  logic signed [P-1:0] pa, pb, pc, pd, pe, pf;
  logic signed [P-1:0] det, nx, ny;
  logic [P-1:0] dm_q, xr_q, xq_q, yr_q, yq_q, xn_q, yn_q;
  logic dn_q, xs_q, ys_q;
  logic [P:0] xt, yt;

  always_comb begin
    det = pa - pb;
    nx  = pc - pd;
    ny  = pe - pf;
    xt  = {xr_q[P-1:0], xn_q[P-1]};
    yt  = {yr_q[P-1:0], yn_q[P-1]};
  end

  // signed quotient from magnitude, saturated to the point width
  function automatic lepi_pkg::cross_t qsat(input logic [P-1:0] q, input logic neg);
    logic [P+C-1:0] m;
    logic [P+C-1:0] lim;
    lim = (P+C)'(1) << (C-1);
    m   = (P+C)'(q);
    if (m > lim - 1'b1) m = neg ? lim : lim - 1'b1;
    return neg ? C'(-m) : C'(m);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pst_q  <= lepi_pkg::StStart;
      sign_q <= 1'b0;
      mag_q  <= '0;
      line_q <= 1'b0;
      pok_q  <= 1'b1;
      for (int i = 0; i < 6; i++) store_q[i] <= '0;
    end else begin
      if (cmd_i.char_step && pst_d != lepi_pkg::StErr) begin
        mag_q <= commit ? '0 : mag_new;
        if (commit) store_q[idx] <= sat;
        if (col == lepi_pkg::ColSign) sign_q <= (ch_i == 8'h2d);
        else if (commit) sign_q <= 1'b0;
      end
      if (cmd_i.char_step) pst_q <= pst_d;
      if (cmd_i.line_end) begin
        pst_q  <= lepi_pkg::StStart;
        sign_q <= 1'b0;
        mag_q  <= '0;
        if (pst_q != lepi_pkg::StAccept) pok_q <= 1'b0;
        if (!line_q) line_q <= 1'b1;
      end
      if (cmd_i.clear_all) begin
        line_q <= 1'b0;
        pok_q  <= 1'b1;
        for (int i = 0; i < 6; i++) store_q[i] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_start) begin
      pa <= P'(store_q[0] * store_q[4]); pb <= P'(store_q[3] * store_q[1]);
      pc <= P'(store_q[5] * store_q[1]); pd <= P'(store_q[2] * store_q[4]);
      pe <= P'(store_q[3] * store_q[2]); pf <= P'(store_q[0] * store_q[5]);
    end
    if (cmd_i.div_load) begin
      dn_q <= det[P-1]; xs_q <= nx[P-1]; ys_q <= ny[P-1];
      dm_q <= det[P-1] ? P'(-det) : P'(det);
      xn_q <= nx[P-1] ? P'(-nx) : P'(nx);
      yn_q <= ny[P-1] ? P'(-ny) : P'(ny);
      xr_q <= '0; yr_q <= '0; xq_q <= '0; yq_q <= '0;
    end
    if (cmd_i.div_step) begin
      xn_q <= xn_q << 1; yn_q <= yn_q << 1;
      if (xt >= {1'b0, dm_q}) begin xr_q <= P'(xt - {1'b0, dm_q}); xq_q <= {xq_q[P-2:0], 1'b1}; end
      else begin xr_q <= xt[P-1:0]; xq_q <= {xq_q[P-2:0], 1'b0}; end
      if (yt >= {1'b0, dm_q}) begin yr_q <= P'(yt - {1'b0, dm_q}); yq_q <= {yq_q[P-2:0], 1'b1}; end
      else begin yr_q <= yt[P-1:0]; yq_q <= {yq_q[P-2:0], 1'b0}; end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (!(out_valid_i && out_stall_i)) begin
      if (cmd_i.line_end) begin
        line_index_o <= line_q;
        line_valid_o <= (pst_q == lepi_pkg::StAccept);
        coef_x_o     <= store_q[line_q ? 3 : 0];
        coef_y_o     <= store_q[line_q ? 4 : 1];
        coef_const_o <= store_q[line_q ? 5 : 2];
        pair_done_o  <= 1'b0;
        pair_valid_o <= 1'b0;
        parallel_o   <= 1'b0;
        cross_x_o    <= '0;
        cross_y_o    <= '0;
      end
      if (cmd_i.clear_all) begin
        pair_done_o  <= 1'b1;
        pair_valid_o <= pok_q;
        parallel_o   <= pok_q && (dm_q == '0);
        cross_x_o    <= (pok_q && dm_q != '0) ? qsat(xq_q, xs_q != dn_q) : '0;
        cross_y_o    <= (pok_q && dm_q != '0) ? qsat(yq_q, ys_q != dn_q) : '0;
      end
    end
  end

  assign sts_o.cur_line = line_q;

endmodule

[hw/rtl/linear_equation_parse_intersect.sv]
// Parses one character per cycle; a zero byte ends a line and yields one item.
// A first line item appears the cycle after its zero byte. Ending the second line
// runs six products then a 49-step restoring divider before that item appears;
// input stalls meanwhile, and whenever a waiting item is stalled.
module linear_equation_parse_intersect (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       ch_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             line_index_o,
  output logic             line_valid_o,
  output lepi_pkg::coef_t  coef_x_o,
  output lepi_pkg::coef_t  coef_y_o,
  output lepi_pkg::coef_t  coef_const_o,
  output logic             pair_done_o,
  output logic             pair_valid_o,
  output logic             parallel_o,
  output lepi_pkg::cross_t cross_x_o,
  output lepi_pkg::cross_t cross_y_o
);

  lepi_pkg::cmd_t cmd;
  lepi_pkg::sts_t sts;

  lepi_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .ch_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  lepi_dp u_dp (
    .clk_i, .rst_ni, .ch_i, .cmd_i(cmd), .out_stall_i, .out_valid_i(out_valid_o),
    .sts_o(sts), .line_index_o, .line_valid_o, .coef_x_o, .coef_y_o, .coef_const_o,
    .pair_done_o, .pair_valid_o, .parallel_o, .cross_x_o, .cross_y_o
  );

endmodule

[hw/rtl/lepi_checker.sv]
module lepi_props (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic line_index_o,
  input logic pair_done_o,
  input logic parallel_o,
  input logic pair_valid_o,
  input lepi_pkg::cross_t cross_x_o
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");

  // a stalled result blocks the input
  a_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o) else $error("input open on full");

  // pair flag only on second line
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pair_done_o |-> line_index_o) else $error("pair on first line");

  // parallel implies zero x coordinate
  a_par: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && parallel_o |-> cross_x_o == '0) else $error("parallel point");

  // invalid pair has no parallel flag
  a_inv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pair_valid_o |-> !parallel_o) else $error("flag on invalid");

endmodule

bind linear_equation_parse_intersect lepi_props u_props (.*);
